FILE: rtl/core/srt_pkg.sv
// srt_pkg: shared types, codes and defaults for the section reference tracker.
// Used by every module under rtl/core; depends on nothing.
package srt_pkg;

    localparam int BUFFER_ENTRIES_DEFAULT  = 1024;
    localparam int SECTION_ENTRIES_DEFAULT = 64;

    localparam logic [63:0] ALL_ONES = '1;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_ALLOCATE = 3'd1,
        OP_FREE     = 3'd2,
        OP_SET_BASE = 3'd3,
        OP_FALLBACK = 3'd4,
        OP_PLAN     = 3'd5,
        OP_DISCARD  = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ERR_OK               = 4'd0,
        ERR_UNKNOWN_BUFFER   = 4'd1,
        ERR_NOT_IN_SECTION   = 4'd2,
        ERR_ALLOC_AFTER_FREE = 4'd3,
        ERR_BAD_FREE         = 4'd4,
        ERR_BASE_CONFLICT    = 4'd5,
        ERR_PLAN_STATE       = 4'd6,
        ERR_UNDERFLOW        = 4'd7,
        ERR_ALREADY_REG      = 4'd8
    } err_t;

    typedef enum logic [1:0] {
        ST_UNALLOC = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_FREED   = 2'd2
    } bstate_t;

    typedef struct packed {
        logic    registered;
        bstate_t state;
    } buf_entry_t;

    typedef struct packed {
        logic [63:0] result_offset;
        logic        first_in_section;
        logic        should_release;
        logic        section_in_use;
        err_t        error_code;
    } result_t;

    // write strobes from the execute logic
    typedef struct packed {
        logic buf_wr;
        logic sec_wr;
        logic plan_set;
        logic plan_clr;
    } ctl_t;

endpackage

FILE: rtl/core/srt_buf_mem.sv
// srt_buf_mem: per-buffer state memory (registered bit + state) with a
// clearing sweep after reset. Depends on srt_pkg.
module srt_buf_mem
    import srt_pkg::*;
#(
    parameter int BUFFER_ENTRIES = BUFFER_ENTRIES_DEFAULT,
    parameter int BW             = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [BW-1:0] rd_addr,
    output buf_entry_t    rd_data,
    input  logic          wr_en,
    input  logic [BW-1:0] wr_addr,
    input  buf_entry_t    wr_data,
    output logic          clearing
);

    buf_entry_t    mem [BUFFER_ENTRIES];
    buf_entry_t    rd_data_reg;
    logic          clear_reg;
    logic          clear_next;
    logic [BW-1:0] clear_addr_reg;
    logic [BW-1:0] clear_addr_next;
    logic          we;
    logic [BW-1:0] wa;
    buf_entry_t    wd;

    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + BW'(1);
            if (clear_addr_reg == BW'(BUFFER_ENTRIES - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    assign we = clear_reg | wr_en;
    assign wa = clear_reg ? clear_addr_reg : wr_addr;
    assign wd = clear_reg ? buf_entry_t'('0) : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // new data wins when the word being read is written in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= (we && (wa == rd_addr)) ? wd : mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

FILE: rtl/core/srt_sec_mem.sv
// srt_sec_mem: per-section counts and base address, with per-entry valid
// bits so that an unwritten section reads as its reset value. Depends on srt_pkg.
module srt_sec_mem
    import srt_pkg::*;
#(
    parameter int SECTION_ENTRIES = SECTION_ENTRIES_DEFAULT,
    parameter int SW              = (SECTION_ENTRIES > 1) ? $clog2(SECTION_ENTRIES) : 1,
    parameter int CW              = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [CW-1:0] rd_ua,
    output logic [CW-1:0] rd_al,
    output logic [CW-1:0] rd_fr,
    output logic [63:0]   rd_base,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [CW-1:0] wr_ua,
    input  logic [CW-1:0] wr_al,
    input  logic [CW-1:0] wr_fr,
    input  logic [63:0]   wr_base
);

    localparam int EW = 3 * CW + 64;
    localparam logic [EW-1:0] ENTRY_RESET = {{(3 * CW){1'b0}}, ALL_ONES};

    logic [EW-1:0]              mem [SECTION_ENTRIES];
    logic [SECTION_ENTRIES-1:0] valid_reg;
    logic [EW-1:0]              rd_data_reg;
    logic [EW-1:0]              wd;

    assign wd = {wr_ua, wr_al, wr_fr, wr_base};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wd;
            end
            else
            begin
                rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : ENTRY_RESET;
            end
        end
    end

    assign rd_ua   = rd_data_reg[EW-1 -: CW];
    assign rd_al   = rd_data_reg[EW-1-CW -: CW];
    assign rd_fr   = rd_data_reg[EW-1-2*CW -: CW];
    assign rd_base = rd_data_reg[63:0];

endmodule

FILE: rtl/core/srt_exec.sv
// srt_exec: combinational decode and update of one operation from the buffer
// and section entries read for it. Depends on srt_pkg.
module srt_exec
    import srt_pkg::*;
#(
    parameter int BUFFER_ENTRIES  = BUFFER_ENTRIES_DEFAULT,
    parameter int SECTION_ENTRIES = SECTION_ENTRIES_DEFAULT,
    parameter int CW              = 11
)
(
    input  logic [2:0]    opcode,
    input  logic [9:0]    buffer_index,
    input  logic [5:0]    section_id,
    input  logic          in_section,
    input  logic [63:0]   offset_from_base,
    input  logic [63:0]   base_address,
    input  logic [63:0]   present_offset,
    input  logic          rollback,
    input  buf_entry_t    buf_rd,
    input  logic [CW-1:0] ua,
    input  logic [CW-1:0] al,
    input  logic [CW-1:0] fr,
    input  logic [63:0]   base,
    input  logic          planned,
    output result_t       res,
    output ctl_t          ctl,
    output buf_entry_t    buf_wd,
    output logic [CW-1:0] ua_n,
    output logic [CW-1:0] al_n,
    output logic [CW-1:0] fr_n,
    output logic [63:0]   base_n
);

    op_t     op;
    bstate_t st;
    logic    b_ok;
    logic    s_ok;
    logic    empties;

    assign op      = op_t'(opcode);
    assign st      = buf_rd.state;
    assign b_ok    = 17'(buffer_index) < 17'(BUFFER_ENTRIES);
    assign s_ok    = 7'(section_id) < 7'(SECTION_ENTRIES);
    assign empties = (fr == CW'(1)) && (al == '0);

    always_comb
    begin
        res.result_offset    = '0;
        res.first_in_section = 1'b0;
        res.should_release   = 1'b0;
        res.section_in_use   = 1'b0;
        res.error_code       = ERR_OK;
        ctl                  = '0;
        buf_wd.registered    = 1'b1;
        buf_wd.state         = ST_UNALLOC;
        ua_n                 = ua;
        al_n                 = al;
        fr_n                 = fr;
        base_n               = base;

        unique case (op)
            OP_NOP:
            begin
            end
            OP_DISCARD:
            begin
                ctl.plan_clr = 1'b1;
            end
            OP_SET_BASE:
            begin
                if (!s_ok)
                begin
                    res.error_code = ERR_NOT_IN_SECTION;
                end
                else if (base_address != ALL_ONES)
                begin
                    if (base != ALL_ONES || al != CW'(1) || fr != '0)
                    begin
                        res.error_code = ERR_BASE_CONFLICT;
                    end
                end
                else if (base == ALL_ONES || al != '0 || fr != '0)
                begin
                    res.error_code = ERR_BASE_CONFLICT;
                end
                if (res.error_code == ERR_OK)
                begin
                    ctl.sec_wr = 1'b1;
                    base_n     = base_address;
                end
            end
            default:
            begin
                // buffer operations: common checks first
                if (!in_section)
                begin
                    if (op != OP_FALLBACK && op != OP_PLAN)
                    begin
                        res.error_code = ERR_NOT_IN_SECTION;
                    end
                end
                else if (!b_ok)
                begin
                    res.error_code = ERR_UNKNOWN_BUFFER;
                end
                else if (!s_ok)
                begin
                    res.error_code = ERR_NOT_IN_SECTION;
                end
                else if (op == OP_REGISTER)
                begin
                    if (buf_rd.registered)
                    begin
                        res.error_code = ERR_ALREADY_REG;
                    end
                    else
                    begin
                        ctl.buf_wr = 1'b1;
                        ctl.sec_wr = 1'b1;
                        ua_n       = ua + CW'(1);
                    end
                end
                else if (!buf_rd.registered)
                begin
                    res.error_code = ERR_UNKNOWN_BUFFER;
                end
                else if (op == OP_ALLOCATE)
                begin
                    if (st == ST_ALLOC)
                    begin
                        res.result_offset = present_offset;
                    end
                    else if (st != ST_UNALLOC)
                    begin
                        res.error_code = ERR_ALLOC_AFTER_FREE;
                    end
                    else if (ua == '0)
                    begin
                        res.error_code = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        if (al == '0 && fr == '0)
                        begin
                            res.first_in_section = 1'b1;
                            res.result_offset    = ALL_ONES;
                        end
                        else
                        begin
                            res.result_offset = base + offset_from_base;
                        end
                        ua_n         = ua - CW'(1);
                        al_n         = al + CW'(1);
                        buf_wd.state = ST_ALLOC;
                        ctl.buf_wr   = 1'b1;
                        ctl.sec_wr   = 1'b1;
                    end
                end
                else if (op == OP_FREE)
                begin
                    if (st == ST_ALLOC)
                    begin
                        if (al == '0)
                        begin
                            res.error_code = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            al_n = al - CW'(1);
                        end
                    end
                    else if (st == ST_FREED)
                    begin
                        if (fr == '0)
                        begin
                            res.error_code = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            fr_n = fr - CW'(1);
                        end
                    end
                    else
                    begin
                        res.error_code = ERR_BAD_FREE;
                    end
                    if (res.error_code == ERR_OK)
                    begin
                        if (rollback)
                        begin
                            ua_n         = ua + CW'(1);
                            buf_wd.state = ST_UNALLOC;
                        end
                        else
                        begin
                            fr_n         = fr_n + CW'(1);
                            buf_wd.state = ST_FREED;
                        end
                        ctl.buf_wr         = 1'b1;
                        ctl.sec_wr         = 1'b1;
                        res.should_release = (al_n == '0) && ((fr_n == '0) || (ua_n == '0));
                    end
                end
                else if (op == OP_FALLBACK)
                begin
                    if (st == ST_FREED)
                    begin
                        if (fr == '0)
                        begin
                            res.error_code = ERR_UNDERFLOW;
                        end
                        else if (empties && base == ALL_ONES)
                        begin
                            res.error_code = ERR_BASE_CONFLICT;
                        end
                        else
                        begin
                            fr_n = fr - CW'(1);
                            ua_n = ua + CW'(1);
                            if (empties)
                            begin
                                base_n = ALL_ONES;
                            end
                            buf_wd.state = ST_UNALLOC;
                            ctl.buf_wr   = 1'b1;
                            ctl.sec_wr   = 1'b1;
                        end
                    end
                    else if (st != ST_UNALLOC)
                    begin
                        res.error_code = ERR_BAD_FREE;
                    end
                end
                else
                begin
                    // plan
                    if (st != ST_UNALLOC)
                    begin
                        res.error_code = ERR_PLAN_STATE;
                    end
                    else if (planned)
                    begin
                        res.section_in_use = 1'b1;
                    end
                    else if (ua == '0)
                    begin
                        res.error_code = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.plan_set       = 1'b1;
                        res.section_in_use = (al != '0) || (fr != '0);
                    end
                end
            end
        endcase

        if (res.error_code != ERR_OK)
        begin
            res.result_offset    = '0;
            res.first_in_section = 1'b0;
            res.should_release   = 1'b0;
            res.section_in_use   = 1'b0;
        end
    end

endmodule

FILE: rtl/core/section_reference_tracker.sv
// section_reference_tracker: top level; input stage, memories, execute logic
// and result register. Depends on srt_pkg, srt_buf_mem, srt_sec_mem, srt_exec.
// Pipeline: two register stages, the execute stage and the result register.
// Throughput: one word per cycle unless out_ready stalls; entries are written back
// as the result registers, with same-address forwarding, so back-to-back words hold.
// Reset: async active low, then a sweep clearing every buffer entry, in_ready low.
module section_reference_tracker
    import srt_pkg::*;
#(
    parameter int BUFFER_ENTRIES  = BUFFER_ENTRIES_DEFAULT,
    parameter int SECTION_ENTRIES = SECTION_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [9:0]  buffer_index,
    input  logic [5:0]  section_id,
    input  logic        in_section,
    input  logic [63:0] offset_from_base,
    input  logic [63:0] base_address,
    input  logic [63:0] present_offset,
    input  logic        rollback,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_offset,
    output logic        first_in_section,
    output logic        should_release,
    output logic        section_in_use,
    output logic [3:0]  error_code
);

    localparam int BW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
    localparam int SW = (SECTION_ENTRIES > 1) ? $clog2(SECTION_ENTRIES) : 1;
    // counts are bounded by the number of registered buffers
    localparam int CW = $clog2(BUFFER_ENTRIES + 1);

    // execute stage: the word held here sees its memory read data
    logic        s1_valid_reg;
    logic [2:0]  s1_opcode_reg;
    logic [9:0]  s1_buffer_index_reg;
    logic [5:0]  s1_section_id_reg;
    logic        s1_in_section_reg;
    logic [63:0] s1_offset_reg;
    logic [63:0] s1_base_address_reg;
    logic [63:0] s1_present_reg;
    logic        s1_rollback_reg;

    // result register
    logic        out_valid_reg;
    logic [63:0] result_offset_reg;
    logic        first_in_section_reg;
    logic        should_release_reg;
    logic        section_in_use_reg;
    logic [3:0]  error_code_reg;

    logic [SECTION_ENTRIES-1:0] planned_reg;
    logic [SECTION_ENTRIES-1:0] planned_next;

    logic          accept;
    logic          advance;
    logic          clearing;
    logic [16:0]   in_idx_wide;
    logic [16:0]   s1_idx_wide;
    logic [BW-1:0] buf_rd_addr;
    logic [BW-1:0] buf_wr_addr;
    logic [SW-1:0] sec_rd_addr;
    logic [SW-1:0] sec_wr_addr;

    buf_entry_t    buf_rd;
    buf_entry_t    buf_wd;
    logic [CW-1:0] ua;
    logic [CW-1:0] al;
    logic [CW-1:0] fr;
    logic [63:0]   base;
    logic [CW-1:0] ua_n;
    logic [CW-1:0] al_n;
    logic [CW-1:0] fr_n;
    logic [63:0]   base_n;
    result_t       res;
    ctl_t          ctl;

    // the execute stage moves on whenever the result register is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing && (!s1_valid_reg || advance);
    assign accept   = in_valid && in_ready;

    assign in_idx_wide = 17'(buffer_index);
    assign s1_idx_wide = 17'(s1_buffer_index_reg);
    assign buf_rd_addr = in_idx_wide[BW-1:0];
    assign buf_wr_addr = s1_idx_wide[BW-1:0];
    assign sec_rd_addr = section_id[SW-1:0];
    assign sec_wr_addr = s1_section_id_reg[SW-1:0];

    srt_buf_mem #(
        .BUFFER_ENTRIES (BUFFER_ENTRIES),
        .BW             (BW)
    ) u_buf_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (buf_rd_addr),
        .rd_data  (buf_rd),
        .wr_en    (advance && ctl.buf_wr),
        .wr_addr  (buf_wr_addr),
        .wr_data  (buf_wd),
        .clearing (clearing)
    );

    srt_sec_mem #(
        .SECTION_ENTRIES (SECTION_ENTRIES),
        .SW              (SW),
        .CW              (CW)
    ) u_sec_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (sec_rd_addr),
        .rd_ua   (ua),
        .rd_al   (al),
        .rd_fr   (fr),
        .rd_base (base),
        .wr_en   (advance && ctl.sec_wr),
        .wr_addr (sec_wr_addr),
        .wr_ua   (ua_n),
        .wr_al   (al_n),
        .wr_fr   (fr_n),
        .wr_base (base_n)
    );

    srt_exec #(
        .BUFFER_ENTRIES  (BUFFER_ENTRIES),
        .SECTION_ENTRIES (SECTION_ENTRIES),
        .CW              (CW)
    ) u_exec (
        .opcode           (s1_opcode_reg),
        .buffer_index     (s1_buffer_index_reg),
        .section_id       (s1_section_id_reg),
        .in_section       (s1_in_section_reg),
        .offset_from_base (s1_offset_reg),
        .base_address     (s1_base_address_reg),
        .present_offset   (s1_present_reg),
        .rollback         (s1_rollback_reg),
        .buf_rd           (buf_rd),
        .ua               (ua),
        .al               (al),
        .fr               (fr),
        .base             (base),
        .planned          (planned_reg[sec_wr_addr]),
        .res              (res),
        .ctl              (ctl),
        .buf_wd           (buf_wd),
        .ua_n             (ua_n),
        .al_n             (al_n),
        .fr_n             (fr_n),
        .base_n           (base_n)
    );

    // plan bits live in flops and are read directly by the execute stage
    always_comb
    begin
        planned_next = planned_reg;
        if (advance && ctl.plan_clr)
        begin
            planned_next = '0;
        end
        else if (advance && ctl.plan_set)
        begin
            planned_next[sec_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            planned_reg   <= '0;
        end
        else
        begin
            planned_reg <= planned_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg       <= opcode;
            s1_buffer_index_reg <= buffer_index;
            s1_section_id_reg   <= section_id;
            s1_in_section_reg   <= in_section;
            s1_offset_reg       <= offset_from_base;
            s1_base_address_reg <= base_address;
            s1_present_reg      <= present_offset;
            s1_rollback_reg     <= rollback;
        end
        if (advance)
        begin
            result_offset_reg    <= res.result_offset;
            first_in_section_reg <= res.first_in_section;
            should_release_reg   <= res.should_release;
            section_in_use_reg   <= res.section_in_use;
            error_code_reg       <= res.error_code;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_offset    = result_offset_reg;
    assign first_in_section = first_in_section_reg;
    assign should_release   = should_release_reg;
    assign section_in_use   = section_in_use_reg;
    assign error_code       = error_code_reg;

endmodule

FILE: verif/section_reference_tracker_test.sv
// section_reference_tracker_test: self-checking bench for the section reference tracker.
// Needs srt_pkg and section_reference_tracker; drives words through valid/ready and
// checks each result against a behavioral tracker kept inside the bench.
module section_reference_tracker_test
    import srt_pkg::*;
();

    // One input word as the bench holds it; drain makes the driver hold it back
    // until every outstanding result has come home.
    typedef struct {
        op_t         op;
        logic [9:0]  bidx;
        logic [5:0]  sid;
        logic        insec;
        logic [63:0] ofs;
        logic [63:0] base;
        logic [63:0] present;
        logic        rb;
        bit          drain;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [9:0]  buffer_index = '0;
    logic [5:0]  section_id = '0;
    logic        in_section = 1'b0;
    logic [63:0] offset_from_base = '0;
    logic [63:0] base_address = '0;
    logic [63:0] present_offset = '0;
    logic        rollback = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_offset;
    logic        first_in_section;
    logic        should_release;
    logic        section_in_use;
    logic [3:0]  error_code;

    section_reference_tracker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .buffer_index     (buffer_index),
        .section_id       (section_id),
        .in_section       (in_section),
        .offset_from_base (offset_from_base),
        .base_address     (base_address),
        .present_offset   (present_offset),
        .rollback         (rollback),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_offset    (result_offset),
        .first_in_section (first_in_section),
        .should_release   (should_release),
        .section_in_use   (section_in_use),
        .error_code       (error_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the tracker state
    // ------------------------------------------------------------------
    bstate_t     buf_state_m [1024];
    bit          buf_reg_m   [1024];
    int unsigned unalloc_cnt [64];
    int unsigned alloc_cnt   [64];
    int unsigned freed_cnt   [64];
    logic [63:0] sec_base    [64];
    logic [63:0] planned_mask;

    word_t   word_q[$];       // words waiting for the driver
    result_t expected_q[$];   // predicted results, oldest first
    word_t   cur_word;
    int      fail_count = 0;
    int      send_gap = 0;
    int      recv_stall = 0;
    bit      send_calm = 1'b0;
    bit      recv_calm = 1'b0;

    // Applies one accepted word to the shadow state and returns the result the
    // block must produce. Any failed check leaves the state as it was and
    // zeroes everything but the error code.
    function automatic result_t track_word(word_t w);
        result_t     r;
        logic [63:0] off;
        logic        first;
        logic        rel;
        logic        busy;
        logic        empties;
        err_t        e;
        bstate_t     st;
        int          b;
        int          s;
        r     = '0;
        off   = '0;
        first = 1'b0;
        rel   = 1'b0;
        busy  = 1'b0;
        e     = ERR_OK;
        b     = int'(w.bidx);
        s     = int'(w.sid);

        if (w.op == OP_NOP)
            return r;
        if (w.op == OP_DISCARD)
        begin
            planned_mask = '0;
            return r;
        end

        if (w.op == OP_SET_BASE)
        begin
            // setting needs an unset base and exactly one live buffer;
            // unsetting needs a set base and an idle section
            if (w.base != ALL_ONES)
            begin
                if (sec_base[s] != ALL_ONES || alloc_cnt[s] != 1 || freed_cnt[s] != 0)
                    e = ERR_BASE_CONFLICT;
            end
            else if (sec_base[s] == ALL_ONES || alloc_cnt[s] != 0 || freed_cnt[s] != 0)
                e = ERR_BASE_CONFLICT;
            if (e == ERR_OK)
                sec_base[s] = w.base;
            r.error_code = e;
            return r;
        end

        // fallback and plan quietly ignore buffers without a section
        if (!w.insec)
        begin
            if (w.op != OP_FALLBACK && w.op != OP_PLAN)
                r.error_code = ERR_NOT_IN_SECTION;
            return r;
        end

        // index ranges match the port widths, so no range errors can occur
        if (w.op == OP_REGISTER)
        begin
            if (buf_reg_m[b])
                r.error_code = ERR_ALREADY_REG;
            else
            begin
                buf_reg_m[b]   = 1'b1;
                buf_state_m[b] = ST_UNALLOC;
                unalloc_cnt[s]++;
            end
            return r;
        end

        if (!buf_reg_m[b])
        begin
            r.error_code = ERR_UNKNOWN_BUFFER;
            return r;
        end
        st = buf_state_m[b];

        case (w.op)
            OP_ALLOCATE:
            begin
                if (st == ST_ALLOC)
                    off = w.present;
                else if (st != ST_UNALLOC)
                    e = ERR_ALLOC_AFTER_FREE;
                else if (unalloc_cnt[s] == 0)
                    e = ERR_UNDERFLOW;
                else
                begin
                    if (alloc_cnt[s] == 0 && freed_cnt[s] == 0)
                    begin
                        first = 1'b1;
                        off   = ALL_ONES;
                    end
                    else
                        off = sec_base[s] + w.ofs;
                    unalloc_cnt[s]--;
                    alloc_cnt[s]++;
                    buf_state_m[b] = ST_ALLOC;
                end
            end
            OP_FREE:
            begin
                if (st == ST_ALLOC)
                begin
                    if (alloc_cnt[s] == 0) e = ERR_UNDERFLOW;
                    else alloc_cnt[s]--;
                end
                else if (st == ST_FREED)
                begin
                    if (freed_cnt[s] == 0) e = ERR_UNDERFLOW;
                    else freed_cnt[s]--;
                end
                else
                    e = ERR_BAD_FREE;
                if (e == ERR_OK)
                begin
                    if (w.rb)
                    begin
                        unalloc_cnt[s]++;
                        buf_state_m[b] = ST_UNALLOC;
                    end
                    else
                    begin
                        freed_cnt[s]++;
                        buf_state_m[b] = ST_FREED;
                    end
                    rel = (alloc_cnt[s] == 0) && (freed_cnt[s] == 0 || unalloc_cnt[s] == 0);
                end
            end
            OP_FALLBACK:
            begin
                if (st == ST_FREED)
                begin
                    if (freed_cnt[s] == 0)
                        e = ERR_UNDERFLOW;
                    else
                    begin
                        // the last freed buffer leaving takes the base with it
                        empties = (freed_cnt[s] == 1 && alloc_cnt[s] == 0);
                        if (empties && sec_base[s] == ALL_ONES)
                            e = ERR_BASE_CONFLICT;
                        else
                        begin
                            freed_cnt[s]--;
                            unalloc_cnt[s]++;
                            if (empties)
                                sec_base[s] = ALL_ONES;
                            buf_state_m[b] = ST_UNALLOC;
                        end
                    end
                end
                else if (st != ST_UNALLOC)
                    e = ERR_BAD_FREE;
            end
            default:
            begin
                // plan
                if (st != ST_UNALLOC)
                    e = ERR_PLAN_STATE;
                else if (planned_mask[s])
                    busy = 1'b1;
                else if (unalloc_cnt[s] == 0)
                    e = ERR_UNDERFLOW;
                else
                begin
                    planned_mask[s] = 1'b1;
                    busy = (alloc_cnt[s] != 0 || freed_cnt[s] != 0);
                end
            end
        endcase

        if (e != ERR_OK)
        begin
            r.error_code = e;
            return r;
        end
        r.result_offset    = off;
        r.first_in_section = first;
        r.should_release   = rel;
        r.section_in_use   = busy;
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    // A calm stretch turns idling off altogether.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_word(op_t op, int b, int s, bit insec, logic [63:0] ofs,
                            logic [63:0] base, logic [63:0] present, bit rb, bit drain);
        word_t w;
        w.op      = op;
        w.bidx    = 10'(b);
        w.sid     = 6'(s);
        w.insec   = insec;
        w.ofs     = ofs;
        w.base    = base;
        w.present = present;
        w.rb      = rb;
        w.drain   = drain;
        word_q.insert(word_q.size(), w);
    endtask

    // ------------------------------------------------------------------
    // Driver: one word in flight on the input channel. A new word goes out
    // only when the slot is free (nothing shown or the shown one accepted),
    // so valid never drops before its word is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        bit take;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            take = 1'b0;
            if (in_valid && in_ready)
            begin
                expected_q.insert(expected_q.size(), track_word(cur_word));
                send_gap = pick_gap(send_calm);
                if ($urandom_range(0, 99) < 3)
                    send_calm = !send_calm;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (word_q.size() > 0 && (!word_q[0].drain || expected_q.size() == 0))
                    take = 1'b1;
                if (take)
                begin
                    cur_word         = word_q.pop_front();
                    in_valid         <= 1'b1;
                    opcode           <= cur_word.op;
                    buffer_index     <= cur_word.bidx;
                    section_id       <= cur_word.sid;
                    in_section       <= cur_word.insec;
                    offset_from_base <= cur_word.ofs;
                    base_address     <= cur_word.base;
                    present_offset   <= cur_word.present;
                    rollback         <= cur_word.rb;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes each result word, checks it against the oldest
    // prediction and throttles out_ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        result_t want;
        bit      accept;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            accept = out_valid && out_ready;
            if (accept)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected: offset %h err %0d",
                           result_offset, error_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result_offset !== want.result_offset)
                    begin
                        $error("result_offset: expected %h, got %h",
                               want.result_offset, result_offset);
                        fail_count++;
                    end
                    if (first_in_section !== want.first_in_section)
                    begin
                        $error("first_in_section: expected %0b, got %0b",
                               want.first_in_section, first_in_section);
                        fail_count++;
                    end
                    if (should_release !== want.should_release)
                    begin
                        $error("should_release: expected %0b, got %0b",
                               want.should_release, should_release);
                        fail_count++;
                    end
                    if (section_in_use !== want.section_in_use)
                    begin
                        $error("section_in_use: expected %0b, got %0b",
                               want.section_in_use, section_in_use);
                        fail_count++;
                    end
                    if (error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, error_code);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 99) < 3)
                    recv_calm = !recv_calm;
            end
            // stalls start after a taken word, and now and then while idle
            if (recv_stall > 0)
                recv_stall--;
            else if (accept || $urandom_range(0, 99) < 5)
                recv_stall = pick_gap(recv_calm);
            out_ready <= (recv_stall == 0);
        end
    end

    // Hard stop: covers the clearing sweep over all 1024 buffer entries after reset plus every
    // word meeting the longest gap and the longest stall, several times over.
    initial
    begin
        #2000000;
        $display("FAIL section_reference_tracker");
        $finish;
    end

    initial
    begin : run
        int          pool_buf [40];
        int          pool_sec [40];
        int          sec_pick [6];
        int          p;
        int          r;
        int          k;
        op_t         op;
        logic [63:0] ofs;
        logic [63:0] base;

        foreach (buf_state_m[i])
        begin
            buf_state_m[i] = ST_UNALLOC;
            buf_reg_m[i]   = 1'b0;
        end
        foreach (sec_base[i])
        begin
            unalloc_cnt[i] = 0;
            alloc_cnt[i]   = 0;
            freed_cnt[i]   = 0;
            sec_base[i]    = ALL_ONES;
        end
        planned_mask = '0;

        // ---- directed words ----
        add_word(OP_NOP, 1023, 63, 1, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0);
        add_word(OP_ALLOCATE, 1023, 63, 1, 0, 0, 0, 0, 0);          // unknown buffer
        add_word(OP_REGISTER, 0, 0, 0, 0, 0, 0, 0, 0);              // no section
        add_word(OP_REGISTER, 0, 0, 1, 0, 0, 0, 0, 0);
        add_word(OP_REGISTER, 0, 0, 1, 0, 0, 0, 0, 0);              // registered twice
        add_word(OP_PLAN, 0, 0, 1, 0, 0, 0, 0, 0);                  // new plan
        add_word(OP_PLAN, 0, 0, 1, 0, 0, 0, 0, 0);                  // already planned
        add_word(OP_DISCARD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_word(OP_PLAN, 0, 0, 0, 0, 0, 0, 0, 0);                  // no section: ignored
        add_word(OP_ALLOCATE, 0, 0, 1, 64'h55, 0, 0, 0, 0);         // first in section
        add_word(OP_SET_BASE, 0, 0, 0, 0, 64'h1000, 0, 0, 0);
        add_word(OP_REGISTER, 1023, 0, 1, 0, 0, 0, 0, 0);
        add_word(OP_ALLOCATE, 1023, 0, 1, ALL_ONES, 0, 0, 0, 0);    // base + offset wraps
        add_word(OP_ALLOCATE, 1023, 0, 1, 0, 0, 64'hDEAD_BEEF_0123_4567, 0, 0); // echo
        add_word(OP_PLAN, 0, 0, 1, 0, 0, 0, 0, 0);                  // plan on allocated
        add_word(OP_SET_BASE, 0, 0, 0, 0, 64'h2000, 0, 0, 0);       // base conflict
        add_word(OP_FREE, 1023, 0, 1, 0, 0, 0, 1, 0);               // rollback
        add_word(OP_FREE, 0, 0, 1, 0, 0, 0, 0, 0);
        add_word(OP_ALLOCATE, 0, 0, 1, 0, 0, 0, 0, 0);              // allocate after free
        add_word(OP_FALLBACK, 1023, 0, 1, 0, 0, 0, 0, 0);           // unallocated: no-op
        add_word(OP_FALLBACK, 0, 0, 1, 0, 0, 0, 0, 0);              // empties, unsets base
        add_word(OP_FREE, 0, 0, 1, 0, 0, 0, 0, 0);                  // bad free
        add_word(OP_SET_BASE, 0, 0, 0, 0, ALL_ONES, 0, 0, 0);       // unset while unset
        add_word(OP_REGISTER, 512, 63, 1, 0, 0, 0, 0, 0);
        add_word(OP_PLAN, 512, 62, 1, 0, 0, 0, 0, 0);               // empty section: underflow
        add_word(OP_ALLOCATE, 512, 63, 1, 0, 0, 0, 0, 0);
        add_word(OP_FALLBACK, 512, 63, 1, 0, 0, 0, 0, 0);           // fallback of allocated
        add_word(OP_FREE, 512, 63, 1, 0, 0, 0, 0, 0);               // section may be released
        add_word(OP_FALLBACK, 512, 63, 1, 0, 0, 0, 0, 0);           // empties with base unset

        // ---- random words ----
        // A small pool of buffers spread over a few sections keeps every
        // buffer cycling through its states; the rest is noise.
        foreach (sec_pick[i])
            sec_pick[i] = $urandom_range(0, 63);
        foreach (pool_buf[i])
        begin
            pool_buf[i] = $urandom_range(0, 1023);
            pool_sec[i] = sec_pick[$urandom_range(0, 5)];
        end

        for (k = 0; k < 650; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 1))
                ofs = rand64();
            else
                ofs = 64'($urandom_range(0, 4095));
            if (r < 85)
            begin
                p = $urandom_range(0, 39);
                r = $urandom_range(0, 99);
                if (r < 8)       op = OP_REGISTER;
                else if (r < 33) op = OP_ALLOCATE;
                else if (r < 55) op = OP_FREE;
                else if (r < 67) op = OP_SET_BASE;
                else if (r < 80) op = OP_FALLBACK;
                else if (r < 94) op = OP_PLAN;
                else if (r < 98) op = OP_DISCARD;
                else             op = OP_NOP;
                base = ($urandom_range(0, 99) < 40) ? ALL_ONES : rand64();
                add_word(op, pool_buf[p], pool_sec[p], $urandom_range(0, 99) < 95, ofs,
                         base, rand64(), 1'($urandom_range(0, 1)),
                         k == 0 || $urandom_range(0, 99) == 0);
            end
            else
                add_word(op_t'($urandom_range(0, 7)), $urandom_range(0, 1023),
                         $urandom_range(0, 63), 1'($urandom_range(0, 1)), ofs, rand64(),
                         rand64(), 1'($urandom_range(0, 1)), 1'b0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // all words sent and every prediction matched by a result
        while (word_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        // catch any stray result behind the last one
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("PASS section_reference_tracker");
        else
            $display("FAIL section_reference_tracker");
        $finish;
    end

endmodule
